>>> sv/tun_pkg.sv
package tun_pkg;

    // Default coordinate width of one vertex component.
    localparam int COORD_WIDTH_DEF = 16;

    // Default number of fraction bits in the Q1.x normal components.
    localparam int FRAC_BITS_DEF   = 14;

    // Number of register stages ahead of the divider: edges, cross products,
    // differences, magnitudes, square partial products, squares and the sum.
    localparam int FRONT_STAGES    = 7;

endpackage

>>> sv/triangle_unit_normal.sv
// Triangle unit face normal, fully pipelined.
// The slave channel carries one request per triangle: nine signed vertex
// coordinates a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z packed in tdata.
// The master channel returns one result per triangle: the three Q1.FRAC_BITS
// components of the unit normal in tdata and the degenerate flag in tuser.
// A triangle whose cross product is zero returns a zero vector with the
// degenerate flag set.
// One triangle is accepted every clock cycle unless the receiver stalls the output.
// The pipeline has seven stages for edges, cross product, squares and their
// sum, 2*FRAC_BITS+1 restoring division stages and FRAC_BITS+1 square root
// stages, one bit per stage, then the output register.
// The whole pipeline advances on one enable; when the receiver holds tready
// low with a result waiting, every stage holds its contents and tready on the
// slave side drops, so nothing is lost or repeated.
// The synchronous active low reset clears all valid bits; no result is
// presented until the first triangle has passed through.
module triangle_unit_normal #(
    parameter int COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = tun_pkg::FRAC_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from the lowest bit up
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // normal_x, normal_y, normal_z from the lowest bit up
    output logic [((3*(FRAC_BITS+2)+7)/8)*8-1:0] o_m_tdata,
    // degenerate
    output logic o_m_tuser
);
    import tun_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int EW    = CW + 1;
    localparam int PW    = 2 * EW;
    localparam int NW    = PW + 1;
    localparam int MW    = PW;
    localparam int LW    = MW / 2;
    localparam int HW    = MW - LW;
    localparam int SQW   = 2 * MW;
    localparam int SW    = SQW + 2;
    localparam int RW    = SW + 1;
    localparam int QB    = 2 * FB + 1;
    localparam int DN    = 2 * FB + 1;
    localparam int RN    = FB + 1;
    localparam int RTW   = FB + 1;
    localparam int S2W   = 2 * FB + 3;
    localparam int OW    = FB + 2;
    localparam int OUT_W = ((3*OW+7)/8)*8;
    localparam int NS    = FRONT_STAGES + DN + RN;

    logic          en;
    logic [NS-1:0] r_vld;
    logic          r_ov;

    logic signed [EW-1:0]  r_eu [3];
    logic signed [EW-1:0]  r_ev [3];
    logic signed [PW-1:0]  r_p  [6];
    logic signed [NW-1:0]  r_n  [3];
    logic        [MW-1:0]  r_mag [3];
    logic        [2:0]     r_sg3;
    logic        [2*HW-1:0]  r_hh [3];
    logic        [HW+LW-1:0] r_hl [3];
    logic        [2*LW-1:0]  r_ll [3];
    logic        [2:0]     r_sg4;
    logic        [SQW-1:0] r_sq5 [3];
    logic        [2:0]     r_sg5;
    logic        [SQW-1:0] r_sq6 [3];
    logic        [SW-1:0]  r_sum;
    logic        [2:0]     r_sg6;
    logic                  r_deg6;

    logic [RW-1:0] r_drem [DN][3];
    logic [QB-1:0] r_dq   [DN][3];
    logic [SW-1:0] r_dsum [DN];
    logic [2:0]    r_dsg  [DN];
    logic          r_ddeg [DN];

    logic [RTW-1:0] r_rroot [RN][3];
    logic [S2W-1:0] r_rsq   [RN][3];
    logic [QB-1:0]  r_rq    [RN][3];
    logic [2:0]     r_rsg   [RN];
    logic           r_rdeg  [RN];

    logic [OW-1:0] r_nrm [3];
    logic          r_deg;

    logic signed [CW-1:0] w_a [3];
    logic signed [CW-1:0] w_b [3];
    logic signed [CW-1:0] w_c [3];
    logic signed [NW-1:0] w_nneg [3];
    logic [RW-1:0]  w_srem [DN][3];
    logic [QB-1:0]  w_sq   [DN][3];
    logic [SW-1:0]  w_ssum [DN];
    logic [RW-1:0]  w_drem [DN][3];
    logic [QB-1:0]  w_dq   [DN][3];
    logic [RTW-1:0] w_sroot [RN][3];
    logic [S2W-1:0] w_ssq   [RN][3];
    logic [QB-1:0]  w_srq   [RN][3];
    logic [RTW-1:0] w_root  [RN][3];
    logic [S2W-1:0] w_rsq   [RN][3];
    logic [OW-1:0]  w_nrm   [3];

    // The whole pipeline moves whenever the output register is empty or being read.
    assign en         = ~r_ov | i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OUT_W'({r_nrm[2], r_nrm[1], r_nrm[0]});
    assign o_m_tuser  = r_deg;

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (en) begin
            r_vld <= {r_vld[NS-2:0], i_s_tvalid};
            r_ov  <= r_vld[NS-1];
        end
    end

    // Field unpacking and sign handling of the cross product.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_a[k]    = $signed(i_s_tdata[k*CW +: CW]);
            w_b[k]    = $signed(i_s_tdata[(k+3)*CW +: CW]);
            w_c[k]    = $signed(i_s_tdata[(k+6)*CW +: CW]);
            w_nneg[k] = -r_n[k];
        end
    end

    // Restoring division of each square by the sum, one quotient bit a stage.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_srem[0][k] = RW'(r_sq6[k]);
            w_sq[0][k]   = '0;
        end
        w_ssum[0] = r_sum;
        for (int d = 1; d < DN; d++) begin
            for (int k = 0; k < 3; k++) begin
                w_srem[d][k] = {r_drem[d-1][k][RW-2:0], 1'b0};
                w_sq[d][k]   = r_dq[d-1][k];
            end
            w_ssum[d] = r_dsum[d-1];
        end
        for (int d = 0; d < DN; d++) begin
            for (int k = 0; k < 3; k++) begin
                if (w_srem[d][k] >= RW'(w_ssum[d])) begin
                    w_drem[d][k] = w_srem[d][k] - RW'(w_ssum[d]);
                    w_dq[d][k]   = {w_sq[d][k][QB-2:0], 1'b1};
                end else begin
                    w_drem[d][k] = w_srem[d][k];
                    w_dq[d][k]   = {w_sq[d][k][QB-2:0], 1'b0};
                end
            end
        end
    end

    // Digit by digit square root of the quotient, one root bit a stage.
    always_comb begin
        logic [S2W-1:0] t2;
        t2 = '0;
        for (int k = 0; k < 3; k++) begin
            w_sroot[0][k] = '0;
            w_ssq[0][k]   = '0;
            w_srq[0][k]   = r_dq[DN-1][k];
        end
        for (int j = 1; j < RN; j++) begin
            for (int k = 0; k < 3; k++) begin
                w_sroot[j][k] = r_rroot[j-1][k];
                w_ssq[j][k]   = r_rsq[j-1][k];
                w_srq[j][k]   = r_rq[j-1][k];
            end
        end
        for (int j = 0; j < RN; j++) begin
            for (int k = 0; k < 3; k++) begin
                t2 = w_ssq[j][k] + (S2W'(w_sroot[j][k]) << (FB - j + 1))
                     + (S2W'(1) << (2 * (FB - j)));
                if (t2 <= S2W'(w_srq[j][k])) begin
                    w_root[j][k] = w_sroot[j][k] | (RTW'(1) << (FB - j));
                    w_rsq[j][k]  = t2;
                end else begin
                    w_root[j][k] = w_sroot[j][k];
                    w_rsq[j][k]  = w_ssq[j][k];
                end
            end
        end
    end

    // Sign is applied at the end; a degenerate triangle gives a zero vector.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_rdeg[RN-1]) begin
                w_nrm[k] = '0;
            end else if (r_rsg[RN-1][k]) begin
                w_nrm[k] = -OW'(r_rroot[RN-1][k]);
            end else begin
                w_nrm[k] = OW'(r_rroot[RN-1][k]);
            end
        end
    end

    // Payload registers of every stage.
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_eu[k] <= {w_b[k][CW-1], w_b[k]} - {w_a[k][CW-1], w_a[k]};
                r_ev[k] <= {w_c[k][CW-1], w_c[k]} - {w_a[k][CW-1], w_a[k]};
            end
            r_p[0] <= r_eu[1] * r_ev[2];
            r_p[1] <= r_eu[2] * r_ev[1];
            r_p[2] <= r_eu[2] * r_ev[0];
            r_p[3] <= r_eu[0] * r_ev[2];
            r_p[4] <= r_eu[0] * r_ev[1];
            r_p[5] <= r_eu[1] * r_ev[0];
            for (int k = 0; k < 3; k++) begin
                r_n[k] <= {r_p[2*k][PW-1], r_p[2*k]} - {r_p[2*k+1][PW-1], r_p[2*k+1]};
                r_mag[k] <= r_n[k][NW-1] ? w_nneg[k][MW-1:0] : r_n[k][MW-1:0];
                r_sg3[k] <= r_n[k][NW-1];
                r_hh[k]  <= r_mag[k][MW-1:LW] * r_mag[k][MW-1:LW];
                r_hl[k]  <= r_mag[k][MW-1:LW] * r_mag[k][LW-1:0];
                r_ll[k]  <= r_mag[k][LW-1:0] * r_mag[k][LW-1:0];
                r_sq5[k] <= (SQW'(r_hh[k]) << (2 * LW)) + (SQW'(r_hl[k]) << (LW + 1))
                            + SQW'(r_ll[k]);
                r_sq6[k] <= r_sq5[k];
            end
            r_sg4  <= r_sg3;
            r_sg5  <= r_sg4;
            r_sg6  <= r_sg5;
            r_sum  <= SW'(r_sq5[0]) + SW'(r_sq5[1]) + SW'(r_sq5[2]);
            r_deg6 <= (r_sq5[0] == '0) && (r_sq5[1] == '0) && (r_sq5[2] == '0);

            for (int d = 0; d < DN; d++) begin
                for (int k = 0; k < 3; k++) begin
                    r_drem[d][k] <= w_drem[d][k];
                    r_dq[d][k]   <= w_dq[d][k];
                end
                r_dsum[d] <= w_ssum[d];
                r_dsg[d]  <= (d == 0) ? r_sg6 : r_dsg[(d == 0) ? 0 : d-1];
                r_ddeg[d] <= (d == 0) ? r_deg6 : r_ddeg[(d == 0) ? 0 : d-1];
            end

            for (int j = 0; j < RN; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_rroot[j][k] <= w_root[j][k];
                    r_rsq[j][k]   <= w_rsq[j][k];
                    r_rq[j][k]    <= w_srq[j][k];
                end
                r_rsg[j]  <= (j == 0) ? r_dsg[DN-1] : r_rsg[(j == 0) ? 0 : j-1];
                r_rdeg[j] <= (j == 0) ? r_ddeg[DN-1] : r_rdeg[(j == 0) ? 0 : j-1];
            end

            for (int k = 0; k < 3; k++) begin
                r_nrm[k] <= w_nrm[k];
            end
            r_deg <= r_rdeg[RN-1];
        end
    end

endmodule
